// ----- rtl/core/psfl_pkg.sv -----
package psfl_pkg;

  localparam int ADDR_W    = 32;
  localparam int STAMP_W   = 32;
  localparam int COUNT_W   = 4;
  localparam int BURST_W   = 4;
  localparam int PENALTY_W = 8;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 8;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PENALTY_SECONDS = 1'd1;

  localparam logic [BURST_W-1:0]   BURST_LIMIT_RESET = 4'd6;
  localparam logic [PENALTY_W-1:0] PENALTY_RESET     = 8'd3;
  localparam logic [COUNT_W-1:0]   COUNT_MAX         = 4'd15;
  localparam logic [STAMP_W-1:0]   STAMP_MAX         = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ADDR_W-1:0]  address;
    logic [STAMP_W-1:0] stamp;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   hit;
    logic   stale;
    entry_t entry;
  } hit_info_t;

  function automatic logic [STAMP_W-1:0] sat_add(input logic [STAMP_W-1:0] a,
                                                  input logic [STAMP_W-1:0] b);
    logic [STAMP_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[STAMP_W] ? STAMP_MAX : sum[STAMP_W-1:0];
  endfunction

endpackage

// ----- rtl/core/psfl_ram.sv -----
module psfl_ram #(
  parameter int WIDTH  = 68,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/psfl_update.sv -----
module psfl_update import psfl_pkg::*; (
  input  hit_info_t            info,
  input  logic [ADDR_W-1:0]    source_ip,
  input  logic [STAMP_W-1:0]   now_seconds,
  input  logic [BURST_W-1:0]   burst_limit,
  input  logic [PENALTY_W-1:0] penalty_seconds,
  output entry_t               new_entry,
  output logic                 reject,
  output logic                 known_source
);

  logic [STAMP_W-1:0] base_stamp;
  logic [COUNT_W-1:0] base_count;

  always_comb begin
    base_stamp   = info.stale ? now_seconds : info.entry.stamp;
    base_count   = info.stale ? '0 : info.entry.count;
    reject       = 1'b0;
    known_source = info.hit;
    new_entry.address = source_ip;
    new_entry.stamp   = now_seconds;
    new_entry.count   = '0;
    if (info.hit) begin
      new_entry.address = info.entry.address;
      new_entry.count   = base_count;
      if (base_count > burst_limit) begin
        reject          = 1'b1;
        new_entry.stamp = sat_add(now_seconds, {{(STAMP_W-PENALTY_W){1'b0}}, penalty_seconds});
      end else begin
        new_entry.stamp = sat_add(base_stamp, {{(STAMP_W-1){1'b0}}, 1'b1});
        if (base_count != COUNT_MAX) begin
          new_entry.count = base_count + 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/per_source_flood_limiter.sv -----
// Per-source flood limiter. Each request on the slave stream carries a source
// address and the current time in seconds; one result per request leaves on the
// master stream, telling whether the request is dropped as a flood and whether
// the source was already known. The source table lives in a single-port-read
// RAM that is walked one entry per cycle; the walk stops at the first match, so
// a known source is finished early, and a new request is taken the cycle after
// the result is loaded. Results wait in an output register while the next
// request is accepted. Entries become valid in insertion order, so a fill count
// stands in for valid bits and no clearing pass is needed after reset.
// Configuration is written through cfg_wr_en, cfg_index and cfg_data while no
// request is in flight; the user must keep to this, as it is not enforced.
module per_source_flood_limiter import psfl_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: source_ip[31:0], now_seconds[63:32].
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: reject[0], known_source[1], zero fill[7:2].
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL     = CW'(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0]           state;
  logic [ADDR_W-1:0]    ip_q;
  logic [STAMP_W-1:0]   now_q;
  logic [CW-1:0]        issue_cnt;
  logic                 cmp_valid;
  logic [AW-1:0]        cmp_idx;
  hit_info_t            info;
  logic [AW-1:0]        hit_idx;
  logic [AW-1:0]        replace_ptr;
  logic [AW-1:0]        replace_ptr_next;
  logic [CW-1:0]        fill;
  logic [BURST_W-1:0]   burst_limit;
  logic [PENALTY_W-1:0] penalty_seconds;
  logic                 reject_q;
  logic                 known_q;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [ENTRY_W-1:0]   rd_data;
  entry_t               rd_entry;
  logic                 cmp_entry_valid;
  logic                 cmp_hit;
  logic                 load_result;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  entry_t               new_entry;
  logic                 reject;
  logic                 known_source;

  assign s_tready = (state == ST_IDLE);
  assign m_tdata  = {{(OUT_DATA_W-2){1'b0}}, known_q, reject_q};

  assign rd_en    = (state == ST_SCAN) && (issue_cnt < FULL);
  assign rd_addr  = issue_cnt[AW-1:0];
  assign rd_entry = entry_t'(rd_data);

  assign cmp_entry_valid = (fill == FULL) || ((cmp_idx != '0) && (CW'(cmp_idx) <= fill));
  assign cmp_hit = cmp_valid && cmp_entry_valid && (rd_entry.address == ip_q);

  assign replace_ptr_next = (replace_ptr == LAST_IDX) ? '0 : replace_ptr + 1'b1;

  assign load_result = (state == ST_UPDATE) && (!m_tvalid || m_tready);
  assign mem_we      = load_result;
  assign mem_waddr   = info.hit ? hit_idx : replace_ptr_next;

  psfl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_ENTRIES),
    .ADDR_W(AW)
  ) u_table (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(ENTRY_W'(new_entry)),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  psfl_update u_update (
    .info           (info),
    .source_ip      (ip_q),
    .now_seconds    (now_q),
    .burst_limit    (burst_limit),
    .penalty_seconds(penalty_seconds),
    .new_entry      (new_entry),
    .reject         (reject),
    .known_source   (known_source)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit     <= BURST_LIMIT_RESET;
      penalty_seconds <= PENALTY_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BURST_LIMIT:     burst_limit     <= cfg_data[BURST_W-1:0];
        REG_PENALTY_SECONDS: penalty_seconds <= cfg_data[PENALTY_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      issue_cnt   <= '0;
      cmp_valid   <= 1'b0;
      replace_ptr <= '0;
      fill        <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      cmp_valid <= rd_en;
      if (load_result) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            issue_cnt <= '0;
            state     <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (cmp_hit || (cmp_valid && cmp_idx == LAST_IDX)) begin
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (load_result) begin
            state    <= ST_IDLE;
            if (!info.hit) begin
              replace_ptr <= replace_ptr_next;
              if (fill != FULL) begin
                fill <= fill + 1'b1;
              end
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= rd_addr;
    if (s_tvalid && s_tready) begin
      ip_q  <= s_tdata[ADDR_W-1:0];
      now_q <= s_tdata[IN_DATA_W-1:ADDR_W];
    end
    if (state == ST_SCAN && cmp_valid) begin
      info.hit   <= cmp_hit;
      info.stale <= rd_entry.stamp < now_q;
      info.entry <= rd_entry;
      hit_idx    <= cmp_idx;
    end
    if (load_result) begin
      reject_q <= reject;
      known_q  <= known_source;
    end
  end

  assert property (@(posedge clk) disable iff (rst) fill <= FULL)
    else $error("Fill count ran past the table size.");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_SCAN && !m_tvalid) || (state == ST_SCAN))
    else $error("Accepted request did not start a table walk.");

  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
    else $error("A new source was rejected.");

  assert property (@(posedge clk) disable iff (rst)
    load_result |=> m_tvalid && state == ST_IDLE)
    else $error("Finished request did not present its result.");

  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE && m_tvalid && !m_tready) |=> state == ST_UPDATE)
    else $error("Table update went ahead while the result slot was full.");

endmodule

// ----- tb/tb_per_source_flood_limiter.sv -----
module tb_per_source_flood_limiter;
  import psfl_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 8;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_REQUESTS = 205;
  localparam int POOL_MAX = 24;

  typedef struct packed {
    logic reject;
    logic known_source;
  } verdict_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_BURST_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  per_source_flood_limiter #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [ADDR_W-1:0]    src_addr  [TABLE_ENTRIES];
  logic [STAMP_W-1:0]   src_stamp [TABLE_ENTRIES];
  logic [COUNT_W-1:0]   src_count [TABLE_ENTRIES];
  logic                 src_valid [TABLE_ENTRIES] = '{default: 1'b0};
  int                   victim_slot = 0;
  logic [BURST_W-1:0]   burst_limit = BURST_LIMIT_RESET;
  logic [PENALTY_W-1:0] penalty_seconds = PENALTY_RESET;

  verdict_t verdict_q[$];
  int       mismatches = 0;
  bit       quiet = 1'b0;
  int       holds_asked = 0;
  int       holds_done = 0;
  int       hold_left = 0;

  function automatic logic [STAMP_W-1:0] clip_add(input logic [STAMP_W-1:0] a,
                                                  input logic [STAMP_W-1:0] b);
    logic [STAMP_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[STAMP_W] ? {STAMP_W{1'b1}} : sum[STAMP_W-1:0];
  endfunction

  // The search starts at the replacement slot and wraps; a miss advances the
  // slot first and then claims it.
  function automatic verdict_t judge_request(input logic [ADDR_W-1:0] ip,
                                             input logic [STAMP_W-1:0] now);
    int slot;
    verdict_t v;
    slot = victim_slot;
    for (int n = 0; n < TABLE_ENTRIES; n++) begin
      if (src_valid[slot] && src_addr[slot] == ip) begin
        v.known_source = 1'b1;
        if (src_stamp[slot] < now) begin
          src_stamp[slot] = now;
          src_count[slot] = '0;
        end
        if (src_count[slot] > burst_limit) begin
          src_stamp[slot] = clip_add(now, STAMP_W'(penalty_seconds));
          v.reject = 1'b1;
          return v;
        end
        src_stamp[slot] = clip_add(src_stamp[slot], STAMP_W'(1));
        if (src_count[slot] != COUNT_MAX) src_count[slot] = src_count[slot] + 1'b1;
        v.reject = 1'b0;
        return v;
      end
      slot = (slot + 1) % TABLE_ENTRIES;
    end
    victim_slot = (victim_slot + 1) % TABLE_ENTRIES;
    src_addr[victim_slot] = ip;
    src_stamp[victim_slot] = now;
    src_count[victim_slot] = '0;
    src_valid[victim_slot] = 1'b1;
    v = '0;
    return v;
  endfunction

  task automatic send_request(input logic [ADDR_W-1:0] ip, input logic [STAMP_W-1:0] now);
    if (!quiet && $urandom_range(99) < 7) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 25)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {now, ip};
    do @(posedge clk); while (!s_tready);
    verdict_q.push_back(judge_request(ip, now));
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_BURST_LIMIT: burst_limit = value[BURST_W-1:0];
      REG_PENALTY_SECONDS: penalty_seconds = value[PENALTY_W-1:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request pending: reject %b known_source %b",
                   $realtime, m_tdata[0], m_tdata[1]);
      end else begin
        want = verdict_q.pop_front();
        if (m_tdata[0] !== want.reject || m_tdata[1] !== want.known_source) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: reject exp %b got %b, known_source exp %b got %b", $realtime,
                     want.reject, m_tdata[0], want.known_source, m_tdata[1]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (holds_asked != holds_done) begin
      holds_done <= holds_asked;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 7);
    end
  end

  task automatic test_reset_defaults();
    send_request(32'h0000_0000, 32'd100);
    repeat (8) send_request(32'h0000_0000, 32'd100);
    send_request(32'h0000_0000, 32'd101);
    send_request(32'h0000_0000, 32'd105);
    send_request(32'hFFFF_FFFF, 32'd0);
    drain_results();
  endtask

  task automatic test_stamp_saturation();
    write_register(REG_BURST_LIMIT, 8'd0);
    write_register(REG_PENALTY_SECONDS, 8'hFF);
    repeat (3) send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);
    repeat (3) send_request(32'h8000_0001, 32'hFFFF_FF80);
    drain_results();
  endtask

  task automatic test_backpressure();
    holds_asked++;
    repeat (12) send_request($urandom, $urandom);
    drain_results();
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0]  pool [POOL_MAX];
    logic [STAMP_W-1:0] clock_now;
    logic [ADDR_W-1:0]  ip;
    int pool_size;
    int sent;
    int run;
    int pick;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_register(REG_BURST_LIMIT, 8'd0);
          write_register(REG_PENALTY_SECONDS, 8'd0);
        end
        1: begin
          write_register(REG_BURST_LIMIT, 8'd15);
          write_register(REG_PENALTY_SECONDS, 8'd255);
        end
        2: begin
          write_register(REG_BURST_LIMIT, 8'd14);
          write_register(REG_PENALTY_SECONDS, 8'($urandom_range(255)));
        end
        5: begin
          write_register(REG_BURST_LIMIT, 8'($urandom_range(255)));
          write_register(REG_PENALTY_SECONDS, 8'($urandom_range(255)));
        end
        default: begin
          write_register(REG_BURST_LIMIT, 8'($urandom_range(14)));
          write_register(REG_PENALTY_SECONDS, 8'($urandom_range(255)));
        end
      endcase
      quiet = (phase == 3);
      pool_size = (phase % 2 == 0) ? 10 : POOL_MAX;
      foreach (pool[k]) pool[k] = $urandom;
      if (phase == 4) clock_now = 32'hFFFF_FFFF - $urandom_range(400);
      else if (phase == 6) clock_now = $urandom_range(50);
      else clock_now = $urandom;
      sent = 0;
      while (sent < PHASE_REQUESTS) begin
        pick = $urandom_range(99);
        if (pick < 60) begin
          ip = pool[$urandom_range(pool_size - 1)];
          run = $urandom_range(1, 20);
          repeat (run) begin
            send_request(ip, clock_now);
            sent++;
            if ($urandom_range(9) == 0) clock_now = clock_now + 1;
          end
        end else if (pick < 85) begin
          send_request(pool[$urandom_range(pool_size - 1)], clock_now);
          sent++;
        end else if (pick < 95) begin
          send_request($urandom, clock_now);
          sent++;
        end else begin
          send_request(pool[$urandom_range(pool_size - 1)], $urandom);
          sent++;
        end
        if ($urandom_range(99) < 30) clock_now = clock_now + $urandom_range(1, 4);
        if ($urandom_range(99) == 0) drain_results();
      end
      drain_results();
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_stamp_saturation();
    test_backpressure();
    test_random_traffic();
    drain_results();
    if (verdict_q.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/psfl_pkg.sv
rtl/core/psfl_ram.sv
rtl/core/psfl_update.sv
rtl/core/per_source_flood_limiter.sv
tb/tb_per_source_flood_limiter.sv
